// File: src/tti_pkg.sv
package tti_pkg;

    localparam int MAX_DIMS_DEF   = 6;
    localparam int DIM_BITS_DEF   = 10;
    localparam int INDEX_BITS_DEF = 32;

    localparam int AXIS_BITS      = 3;
    localparam int COUNT_BITS     = 3;
    localparam int CFG_ADDR_BITS  = 2;

    localparam logic [CFG_ADDR_BITS-1:0] CFG_DIM_COUNT   = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_INPUT_SIZES = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_AXIS_ORDER  = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_RANGE  = 2'd1;
    localparam logic [1:0] ST_SINGLE = 2'd2;
    localparam logic [1:0] ST_PERM   = 2'd3;

    localparam logic [COUNT_BITS-1:0] DIM_COUNT_RESET = 3'd2;

    function automatic logic [8*AXIS_BITS-1:0] identity_axes();
        logic [8*AXIS_BITS-1:0] r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            r[i*AXIS_BITS +: AXIS_BITS] = AXIS_BITS'(i);
        end
        return r;
    endfunction

endpackage

// File: src/tensor_transpose_index_map_top.sv
// Permuted-tensor address generator. A request (i_start high, o_busy low) carries a row-major
// index into the transposed tensor; it passes through the input register, the division steps and
// the multiply-add stages, and at the end o_valid pulses for one cycle with the source index and
// status. A new request is taken in every cycle, and o_busy is high only during reset. The
// pipeline holds one restoring-division step per bit of the index for each axis, followed by one
// multiply-add stage per axis that rebuilds the source index. Results cannot be held off, so
// the receiver must take each one in the cycle it is shown. Configuration must only be written
// while no request is in flight.
module tensor_transpose_index_map_top #(
    parameter int MAX_DIMS   = tti_pkg::MAX_DIMS_DEF,
    parameter int DIM_BITS   = tti_pkg::DIM_BITS_DEF,
    parameter int INDEX_BITS = tti_pkg::INDEX_BITS_DEF,
    localparam int SIZE_W    = MAX_DIMS * DIM_BITS,
    localparam int AXES_W    = MAX_DIMS * tti_pkg::AXIS_BITS,
    localparam int CFG_W     = (SIZE_W > AXES_W) ? SIZE_W : AXES_W
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic [INDEX_BITS-1:0]              i_out_index,
    output logic                               o_valid,
    output logic [INDEX_BITS-1:0]              o_src_index,
    output logic [1:0]                         o_status,
    input  logic                               i_cfg_we,
    input  logic [tti_pkg::CFG_ADDR_BITS-1:0]  i_cfg_addr,
    input  logic [CFG_W-1:0]                   i_cfg_data
);
    import tti_pkg::*;

    localparam int S  = MAX_DIMS * INDEX_BITS;
    localparam int DW = DIM_BITS + 1;
    localparam logic [8*AXIS_BITS-1:0] AXES_RESET = identity_axes();

    logic [COUNT_BITS-1:0] r_dim_count;
    logic [SIZE_W-1:0]     r_sizes;
    logic [AXES_W-1:0]     r_axes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_count <= DIM_COUNT_RESET;
            r_sizes     <= '0;
            r_axes      <= AXES_RESET[AXES_W-1:0];
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_DIM_COUNT:   r_dim_count <= i_cfg_data[COUNT_BITS-1:0];
                CFG_INPUT_SIZES: r_sizes     <= i_cfg_data[SIZE_W-1:0];
                CFG_AXIS_ORDER:  r_axes      <= i_cfg_data[AXES_W-1:0];
                default: ;
            endcase
        end
    end

    logic [COUNT_BITS-1:0] w_n;
    logic                  w_single;
    logic                  w_perm_bad;
    logic [DW-1:0]         w_div  [MAX_DIMS];
    logic [DW-1:0]         w_hsz  [MAX_DIMS];
    logic [MAX_DIMS-1:0]   w_mask [MAX_DIMS];

    always_comb begin
        w_n        = (r_dim_count > COUNT_BITS'(MAX_DIMS)) ? COUNT_BITS'(MAX_DIMS) : r_dim_count;
        w_single   = (r_dim_count < COUNT_BITS'(2));
        w_perm_bad = 1'b0;
        for (int i = 0; i < MAX_DIMS; i++) begin
            if (COUNT_BITS'(i) < w_n) begin
                if (r_axes[i*AXIS_BITS +: AXIS_BITS] >= w_n) begin
                    w_perm_bad = 1'b1;
                end
                for (int k = 0; k < i; k++) begin
                    if (r_axes[i*AXIS_BITS +: AXIS_BITS] == r_axes[k*AXIS_BITS +: AXIS_BITS]) begin
                        w_perm_bad = 1'b1;
                    end
                end
            end
        end
        for (int j = 0; j < MAX_DIMS; j++) begin
            w_div[j] = DW'(1);
            for (int i = 0; i < MAX_DIMS; i++) begin
                if ((4'(i) + 4'(j) + 4'd1) == {1'b0, w_n}) begin
                    for (int d = 0; d < MAX_DIMS; d++) begin
                        if (r_axes[i*AXIS_BITS +: AXIS_BITS] == AXIS_BITS'(d)) begin
                            w_div[j] = {1'b0, r_sizes[d*DIM_BITS +: DIM_BITS]} + DW'(1);
                        end
                    end
                end
            end
        end
        for (int d = 0; d < MAX_DIMS; d++) begin
            w_hsz[d]  = (COUNT_BITS'(d) < w_n) ?
                        ({1'b0, r_sizes[d*DIM_BITS +: DIM_BITS]} + DW'(1)) : DW'(1);
            w_mask[d] = '0;
            for (int j = 0; j < MAX_DIMS; j++) begin
                for (int i = 0; i < MAX_DIMS; i++) begin
                    if (((4'(i) + 4'(j) + 4'd1) == {1'b0, w_n}) &&
                        (r_axes[i*AXIS_BITS +: AXIS_BITS] == AXIS_BITS'(d))) begin
                        w_mask[d][j] = 1'b1;
                    end
                end
            end
        end
    end

    logic                  r_v  [0:S];
    logic [INDEX_BITS-1:0] r_dq [0:S];
    logic [DIM_BITS-1:0]   r_rm [0:S];
    logic [SIZE_W-1:0]     r_co [0:S];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_start;
        end
        r_dq[0] <= i_out_index;
        r_rm[0] <= '0;
        r_co[0] <= '0;
    end

    for (genvar s = 0; s < S; s++) begin : g_div
        localparam int J = s / INDEX_BITS;
        localparam int B = s % INDEX_BITS;

        logic [DIM_BITS-1:0]   w_rin;
        logic [DW-1:0]         w_part;
        logic [DW-1:0]         w_diff;
        logic                  w_ge;
        logic [DIM_BITS-1:0]   n_rm;
        logic [SIZE_W-1:0]     n_co;

        if (B == 0) begin : g_first
            assign w_rin = '0;
        end else begin : g_next
            assign w_rin = r_rm[s];
        end

        always_comb begin
            w_part = {w_rin, r_dq[s][INDEX_BITS-1]};
            w_ge   = (w_part >= w_div[J]);
            w_diff = w_part - w_div[J];
            n_rm   = w_ge ? w_diff[DIM_BITS-1:0] : w_part[DIM_BITS-1:0];
            n_co   = r_co[s];
            if (B == INDEX_BITS - 1) begin
                n_co[J*DIM_BITS +: DIM_BITS] = n_rm;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else begin
                r_v[s+1] <= r_v[s];
            end
            r_dq[s+1] <= {r_dq[s][INDEX_BITS-2:0], w_ge};
            r_rm[s+1] <= n_rm;
            r_co[s+1] <= n_co;
        end
    end

    logic                  r_hv  [1:MAX_DIMS];
    logic [INDEX_BITS-1:0] r_acc [1:MAX_DIMS];
    logic [SIZE_W-1:0]     r_hco [1:MAX_DIMS];
    logic                  r_hrg [1:MAX_DIMS];

    for (genvar h = 0; h < MAX_DIMS; h++) begin : g_horner
        logic                     w_v_in;
        logic [INDEX_BITS-1:0]    w_acc_in;
        logic [SIZE_W-1:0]        w_co_in;
        logic                     w_rg_in;
        logic [DIM_BITS-1:0]      w_csel;
        logic [INDEX_BITS+DW-1:0] w_prod;

        if (h == 0) begin : g_head
            assign w_v_in   = r_v[S];
            assign w_acc_in = '0;
            assign w_co_in  = r_co[S];
            assign w_rg_in  = |r_dq[S];
        end else begin : g_body
            assign w_v_in   = r_hv[h];
            assign w_acc_in = r_acc[h];
            assign w_co_in  = r_hco[h];
            assign w_rg_in  = r_hrg[h];
        end

        always_comb begin
            w_csel = '0;
            for (int j = 0; j < MAX_DIMS; j++) begin
                if (w_mask[h][j]) begin
                    w_csel = w_csel | w_co_in[j*DIM_BITS +: DIM_BITS];
                end
            end
            w_prod = w_acc_in * w_hsz[h];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_hv[h+1] <= 1'b0;
            end else begin
                r_hv[h+1] <= w_v_in;
            end
            r_acc[h+1] <= w_prod[INDEX_BITS-1:0] + INDEX_BITS'(w_csel);
            r_hco[h+1] <= w_co_in;
            r_hrg[h+1] <= w_rg_in;
        end
    end

    always_comb begin
        if (w_single) begin
            o_status = ST_SINGLE;
        end else if (w_perm_bad) begin
            o_status = ST_PERM;
        end else if (r_hrg[MAX_DIMS]) begin
            o_status = ST_RANGE;
        end else begin
            o_status = ST_OK;
        end
    end

    assign o_src_index = (o_status == ST_OK) ? r_acc[MAX_DIMS] : '0;
    assign o_valid     = r_hv[MAX_DIMS];
    assign o_busy      = ~i_rst_n;

endmodule

// File: src/tti_check.sv
module tti_check #(
    parameter int LAT        = 198,
    parameter int INDEX_BITS = tti_pkg::INDEX_BITS_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_start,
    input logic                  o_busy,
    input logic [INDEX_BITS-1:0] i_out_index,
    input logic                  o_valid,
    input logic [INDEX_BITS-1:0] o_src_index,
    input logic [1:0]            o_status
);
    import tti_pkg::*;

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |-> (o_src_index == '0))
        else $error("Source index is not zero on an error result.");

    a_result_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy, LAT))
        else $error("Result without a matching request.");

    a_origin_maps_to_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_OK) && ($past(i_out_index, LAT) == '0))
        |-> (o_src_index == '0))
        else $error("Index zero did not map to source index zero.");

endmodule

bind tensor_transpose_index_map_top tti_check #(
    .LAT        (MAX_DIMS * INDEX_BITS + MAX_DIMS + 1),
    .INDEX_BITS (INDEX_BITS)
) u_tti_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .i_out_index (i_out_index),
    .o_valid     (o_valid),
    .o_src_index (o_src_index),
    .o_status    (o_status)
);

// File: tb/tensor_transpose_index_map_top_tb.sv
`timescale 1ns / 1ps

module tensor_transpose_index_map_top_tb;
    import tti_pkg::*;

    localparam int NDIM = MAX_DIMS_DEF;
    localparam int DBITS = DIM_BITS_DEF;
    localparam int IBITS = INDEX_BITS_DEF;
    localparam int CFGW = NDIM * DBITS;
    localparam int AXW = NDIM * AXIS_BITS;
    localparam int LATENCY = NDIM * IBITS + NDIM + 1;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [IBITS-1:0] src_index;
        logic [1:0] status;
    } t_src_result;

    logic i_clk;
    logic i_rst_n;
    logic i_start;
    logic o_busy;
    logic [IBITS-1:0] i_out_index;
    logic o_valid;
    logic [IBITS-1:0] o_src_index;
    logic [1:0] o_status;
    logic i_cfg_we;
    logic [CFG_ADDR_BITS-1:0] i_cfg_addr;
    logic [CFGW-1:0] i_cfg_data;

    logic [2:0] dims_cfg;
    logic [CFGW-1:0] sizes_cfg;
    logic [AXW-1:0] axes_cfg;

    t_src_result pending_src[$];
    int mismatches;
    longint cycles;
    bit allow_gaps;

    tensor_transpose_index_map_top dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .o_busy(o_busy),
        .i_out_index(i_out_index),
        .o_valid(o_valid),
        .o_src_index(o_src_index),
        .o_status(o_status),
        .i_cfg_we(i_cfg_we),
        .i_cfg_addr(i_cfg_addr),
        .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint unsigned element_count();
        int n;
        longint unsigned c;
        n = (int'(dims_cfg) > NDIM) ? NDIM : int'(dims_cfg);
        c = 1;
        for (int d = 0; d < n; d++) begin
            c *= longint'(sizes_cfg[d*DBITS +: DBITS]) + 1;
        end
        return c;
    endfunction

    function automatic t_src_result source_of(logic [IBITS-1:0] idx);
        t_src_result r;
        int n;
        int a;
        int perm[NDIM];
        longint unsigned sz[NDIM];
        longint unsigned stride[NDIM];
        longint unsigned c;
        longint unsigned rem;
        longint unsigned src;
        logic [7:0] seen;
        r.src_index = '0;
        n = (int'(dims_cfg) > NDIM) ? NDIM : int'(dims_cfg);
        if (n < 2) begin
            r.status = ST_SINGLE;
            return r;
        end
        seen = '0;
        for (int i = 0; i < n; i++) begin
            a = int'(axes_cfg[i*AXIS_BITS +: AXIS_BITS]);
            if (a >= n || seen[a]) begin
                r.status = ST_PERM;
                return r;
            end
            seen[a] = 1'b1;
            perm[i] = a;
        end
        c = 1;
        for (int i = n - 1; i >= 0; i--) begin
            sz[i] = longint'(sizes_cfg[i*DBITS +: DBITS]) + 1;
            stride[i] = c;
            c *= sz[i];
        end
        if (longint'(idx) >= c) begin
            r.status = ST_RANGE;
            return r;
        end
        rem = longint'(idx);
        src = 0;
        for (int i = n - 1; i >= 0; i--) begin
            src += (rem % sz[perm[i]]) * stride[perm[i]];
            rem /= sz[perm[i]];
        end
        r.src_index = src[IBITS-1:0];
        r.status = ST_OK;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_src_result want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
        if (i_rst_n && o_valid) begin
            if (pending_src.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: src %h status %0d", o_src_index, o_status);
            end else begin
                want = pending_src.pop_front();
                if (o_src_index !== want.src_index || o_status !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected src %h status %0d, got src %h status %0d",
                                 want.src_index, want.status, o_src_index, o_status);
                end
            end
        end
    end

    task automatic send_request(logic [IBITS-1:0] idx);
        if (allow_gaps && $urandom_range(0, 5) == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_out_index <= idx;
        do @(posedge i_clk); while (o_busy);
        pending_src.push_back(source_of(idx));
    endtask

    task automatic drain();
        i_start <= 1'b0;
        i_out_index <= $urandom;
        @(posedge i_clk);
        while (pending_src.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_config(logic [2:0] dc, logic [CFGW-1:0] sz, logic [AXW-1:0] ax);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_addr <= CFG_DIM_COUNT;
        i_cfg_data <= CFGW'(dc);
        @(posedge i_clk);
        i_cfg_addr <= CFG_INPUT_SIZES;
        i_cfg_data <= sz;
        @(posedge i_clk);
        i_cfg_addr <= CFG_AXIS_ORDER;
        i_cfg_data <= CFGW'(ax);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        dims_cfg = dc;
        sizes_cfg = sz;
        axes_cfg = ax;
    endtask

    function automatic logic [AXW-1:0] shuffled_axes(int n);
        logic [AXW-1:0] ax;
        logic [AXIS_BITS-1:0] t;
        int j;
        ax = AXW'($urandom);
        for (int i = 0; i < NDIM; i++) begin
            if (i < n) ax[i*AXIS_BITS +: AXIS_BITS] = AXIS_BITS'(i);
        end
        for (int i = n - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = ax[i*AXIS_BITS +: AXIS_BITS];
            ax[i*AXIS_BITS +: AXIS_BITS] = ax[j*AXIS_BITS +: AXIS_BITS];
            ax[j*AXIS_BITS +: AXIS_BITS] = t;
        end
        return ax;
    endfunction

    task automatic test_reset_defaults();
        send_request('0);
        send_request(1);
        send_request('1);
    endtask

    task automatic test_too_few_dims();
        set_config(3'd0, '1, shuffled_axes(NDIM));
        send_request('0);
        set_config(3'd1, '0, shuffled_axes(1));
        send_request('0);
        send_request('1);
    endtask

    task automatic test_bad_permutation();
        logic [AXW-1:0] ax;
        ax = shuffled_axes(3);
        ax[2*AXIS_BITS +: AXIS_BITS] = ax[0 +: AXIS_BITS];
        set_config(3'd3, '0, ax);
        send_request('0);
        ax = shuffled_axes(4);
        ax[AXIS_BITS +: AXIS_BITS] = 3'd7;
        set_config(3'd4, '0, ax);
        send_request(2);
    endtask

    task automatic test_extremes();
        logic [AXW-1:0] ax;
        ax = '0;
        for (int i = 0; i < NDIM; i++) ax[i*AXIS_BITS +: AXIS_BITS] = AXIS_BITS'(NDIM - 1 - i);
        set_config(3'd6, '1, ax);
        send_request('1);
        send_request('0);
        send_request(32'h5555_AAAA);
        set_config(3'd7, '1, shuffled_axes(NDIM));
        send_request('1);
        send_request(32'hAAAA_5555);
        set_config(3'd2, {40'd0, 10'd4, 10'd2}, {12'd0, 3'd0, 3'd1});
        for (int i = 0; i < 17; i++) send_request(i);
    endtask

    task automatic test_random_phases();
        logic [2:0] dc;
        logic [CFGW-1:0] sz;
        logic [AXW-1:0] ax;
        longint unsigned c;
        int sel;
        for (int p = 0; p < 20; p++) begin
            allow_gaps = (p < 16);
            sel = $urandom_range(0, 9);
            dc = (sel == 0) ? 3'($urandom_range(0, 1)) :
                 (sel == 1) ? 3'd7 : 3'($urandom_range(2, NDIM));
            sz = CFGW'({$urandom, $urandom});
            for (int d = 0; d < NDIM; d++) begin
                if ($urandom_range(0, 3) != 0) sz[d*DBITS +: DBITS] = DBITS'($urandom_range(0, 7));
            end
            ax = shuffled_axes((int'(dc) > NDIM) ? NDIM : int'(dc));
            if ($urandom_range(0, 6) == 0)
                ax[$urandom_range(0, 2)*AXIS_BITS +: AXIS_BITS] = AXIS_BITS'($urandom);
            set_config(dc, sz, ax);
            c = element_count();
            for (int k = 0; k < 24; k++) begin
                sel = $urandom_range(0, 9);
                if (sel < 6 && c <= 64'hFFFF_FFFF)
                    send_request(IBITS'($urandom_range(0, 32'(c - 1))));
                else if (sel < 8 && c < 64'hFFFF_FF00)
                    send_request(IBITS'(c + $urandom_range(0, 3)));
                else
                    send_request($urandom);
            end
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_start <= 1'b0;
        i_out_index <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_addr <= CFG_DIM_COUNT;
        i_cfg_data <= '0;
        dims_cfg = DIM_COUNT_RESET;
        sizes_cfg = '0;
        axes_cfg = AXW'(identity_axes());
        mismatches = 0;
        cycles = 0;
        allow_gaps = 1'b1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_too_few_dims();
        test_bad_permutation();
        test_extremes();
        test_random_phases();
        drain();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (mismatches == 0 && pending_src.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
src/tti_pkg.sv
src/tensor_transpose_index_map_top.sv
src/tti_check.sv
tb/tensor_transpose_index_map_top_tb.sv
